// ----- hw/rtl/vhit_pkg.sv -----
// ----------------------------------------------------------------------------
// vhit_pkg
// Shared types, constants and helpers for the value handle intern table.
// ----------------------------------------------------------------------------
package vhit_pkg;

	localparam int SLOTS  = 64;
	localparam int SLOT_W = $clog2(SLOTS);

	localparam logic [1:0] OP_INTERN_NUM = 2'd0;
	localparam logic [1:0] OP_INTERN_STR = 2'd1;
	localparam logic [1:0] OP_DECODE     = 2'd2;
	localparam logic [1:0] OP_FETCH_STR  = 2'd3;

	localparam logic [7:0]  NUM_BASE   = 8'd128;
	localparam logic [7:0]  STR_BASE   = 8'd192;
	localparam logic [7:0]  HANDLE_M1  = 8'd255;
	localparam logic [15:0] MINUS_ONE  = 16'hFFFF;
	localparam logic [15:0] EMPTY_MARK = 16'd1;

	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] value;
		logic [15:0] str_ref;
		logic        str_empty;
		logic [7:0]  handle;
	} req_t;

	typedef struct packed {
		logic [7:0]  handle_out;
		logic [15:0] value_out;
		logic        exhausted;
	} rsp_t;

	typedef struct packed {
		logic load;       // capture the accepted item
		logic rd_issue;   // read both tables
		logic rd_next;    // read at the next slot instead of the first
		logic wr;         // store the item in the slot just examined
		logic set_direct;
		logic set_read;
		logic set_hit;
		logic set_full;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic need_scan;
		logic need_read;
		logic hit;
		logic last;
	} dp_sts_t;

	// Contents of a string slot that has never been written.
	function automatic logic [15:0] str_reset_val(input logic [SLOT_W-1:0] a);
		logic [15:0] v;
		v = 16'd0;
		if (a == '0)
			v = EMPTY_MARK;
		else if (a == SLOT_W'(SLOTS - 1))
			v = MINUS_ONE;
		return v;
	endfunction

endpackage

// ----- hw/rtl/vhit_dp.sv -----
// ----------------------------------------------------------------------------
// vhit_dp
// Datapath: item register, both slot tables with valid bits, scan address,
// slot compare and result registers.
// ----------------------------------------------------------------------------
module vhit_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  vhit_pkg::req_t   req,
	input  vhit_pkg::dp_cmd_t cmd,
	output vhit_pkg::dp_sts_t sts,
	output vhit_pkg::rsp_t   rsp
);

	vhit_pkg::req_t item_q;
	vhit_pkg::rsp_t res_q;
	vhit_pkg::rsp_t rsp_q;
	vhit_pkg::rsp_t direct_res;

	logic [15:0] num_mem [vhit_pkg::SLOTS];
	logic [15:0] str_mem [vhit_pkg::SLOTS];
	logic [vhit_pkg::SLOTS-1:0] num_vld_q;
	logic [vhit_pkg::SLOTS-1:0] str_vld_q;

	logic [15:0] num_rd_q;
	logic [15:0] str_rd_q;
	logic [vhit_pkg::SLOT_W-1:0] addr_q;
	logic [vhit_pkg::SLOT_W-1:0] rd_addr;
	logic [vhit_pkg::SLOT_W-1:0] first_addr;

	logic [15:0] num_eff;
	logic [15:0] str_eff;
	logic [5:0]  hidx;
	logic        idx_ok;
	logic        is_num;
	logic        direct_num;

	always_ff @(posedge clk) begin
		if (cmd.load)
			item_q <= req;
	end

	assign hidx   = item_q.handle[5:0];
	assign idx_ok = ({1'b0, hidx} < 7'(vhit_pkg::SLOTS));
	assign is_num = (item_q.op == vhit_pkg::OP_INTERN_NUM);
	assign direct_num = (item_q.value < 16'd128) || (item_q.value == vhit_pkg::MINUS_ONE);

	// A slot never written reads as its reset contents.
	assign num_eff = num_vld_q[addr_q] ? num_rd_q : 16'd0;
	assign str_eff = str_vld_q[addr_q] ? str_rd_q : vhit_pkg::str_reset_val(addr_q);

	always_comb begin
		sts.need_scan = 1'b0;
		sts.need_read = 1'b0;
		case (item_q.op)
			vhit_pkg::OP_INTERN_NUM: sts.need_scan = !direct_num;
			vhit_pkg::OP_INTERN_STR: sts.need_scan = (item_q.str_ref != 16'd0) && !item_q.str_empty;
			vhit_pkg::OP_DECODE: sts.need_read = (item_q.handle >= vhit_pkg::NUM_BASE) &&
				(item_q.handle != vhit_pkg::HANDLE_M1) && idx_ok;
			vhit_pkg::OP_FETCH_STR: sts.need_read = (item_q.handle >= vhit_pkg::STR_BASE) && idx_ok;
			default: ;
		endcase
		sts.hit  = is_num ? ((num_eff == 16'd0) || (num_eff == item_q.value))
		                  : (str_eff == 16'd0);
		sts.last = (addr_q == vhit_pkg::SLOT_W'(vhit_pkg::SLOTS - 1));
	end

	always_comb begin
		direct_res = '0;
		case (item_q.op)
			vhit_pkg::OP_INTERN_NUM: direct_res.handle_out = item_q.value[7:0];
			vhit_pkg::OP_INTERN_STR: begin
				if (item_q.str_ref != 16'd0)
					direct_res.handle_out = vhit_pkg::STR_BASE;
			end
			vhit_pkg::OP_DECODE: begin
				if (item_q.handle < vhit_pkg::NUM_BASE)
					direct_res.value_out = {8'd0, item_q.handle};
				else if (item_q.handle == vhit_pkg::HANDLE_M1)
					direct_res.value_out = vhit_pkg::MINUS_ONE;
			end
			default: ;
		endcase
	end

	// Read address: the first slot of a scan, the handle's slot, or the next slot.
	assign first_addr = sts.need_scan ? vhit_pkg::SLOT_W'(1) : hidx[vhit_pkg::SLOT_W-1:0];
	assign rd_addr    = cmd.rd_next ? addr_q + vhit_pkg::SLOT_W'(1) : first_addr;

	always_ff @(posedge clk) begin
		if (cmd.rd_issue) begin
			num_rd_q <= num_mem[rd_addr];
			str_rd_q <= str_mem[rd_addr];
			addr_q   <= rd_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr && is_num)
			num_mem[addr_q] <= item_q.value;
	end

	always_ff @(posedge clk) begin
		if (cmd.wr && !is_num)
			str_mem[addr_q] <= item_q.str_ref;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_vld_q <= '0;
			str_vld_q <= '0;
		end else if (cmd.wr) begin
			if (is_num)
				num_vld_q[addr_q] <= 1'b1;
			else
				str_vld_q[addr_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.set_direct) begin
			res_q <= direct_res;
		end else if (cmd.set_read) begin
			res_q.handle_out <= 8'd0;
			res_q.value_out  <= (item_q.handle >= vhit_pkg::STR_BASE) ? str_eff : num_eff;
			res_q.exhausted  <= 1'b0;
		end else if (cmd.set_hit) begin
			res_q.handle_out <= (is_num ? vhit_pkg::NUM_BASE : vhit_pkg::STR_BASE) | 8'(addr_q);
			res_q.value_out  <= 16'd0;
			res_q.exhausted  <= 1'b0;
		end else if (cmd.set_full) begin
			res_q.handle_out <= 8'd0;
			res_q.value_out  <= 16'd0;
			res_q.exhausted  <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load)
			rsp_q <= res_q;
	end

	assign rsp = rsp_q;

endmodule

// ----- hw/rtl/vhit_ctrl.sv -----
// ----------------------------------------------------------------------------
// vhit_ctrl
// Controller: sequences one item through classify, table read or slot scan,
// and hands the result to the output register.
// ----------------------------------------------------------------------------
module vhit_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	input  vhit_pkg::dp_sts_t sts,
	output vhit_pkg::dp_cmd_t cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CLASS = 3'd1;
	localparam logic [2:0] S_READ  = 3'd2;
	localparam logic [2:0] S_SCAN  = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       rsp_valid_q;
	logic       out_free;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CLASS;
				end
			end
			S_CLASS: begin
				if (sts.need_scan) begin
					cmd.rd_issue = 1'b1;
					state_d      = S_SCAN;
				end else if (sts.need_read) begin
					cmd.rd_issue = 1'b1;
					state_d      = S_READ;
				end else begin
					cmd.set_direct = 1'b1;
					state_d        = S_DONE;
				end
			end
			S_READ: begin
				cmd.set_read = 1'b1;
				state_d      = S_DONE;
			end
			S_SCAN: begin
				// One slot is examined per cycle while the next one is read.
				if (sts.hit) begin
					cmd.wr      = 1'b1;
					cmd.set_hit = 1'b1;
					state_d     = S_DONE;
				end else if (sts.last) begin
					cmd.set_full = 1'b1;
					state_d      = S_DONE;
				end else begin
					cmd.rd_issue = 1'b1;
					cmd.rd_next  = 1'b1;
				end
			end
			S_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

endmodule

// ----- hw/rtl/value_handle_intern_table.sv -----
// ----------------------------------------------------------------------------
// value_handle_intern_table
// Maps 16-bit numbers and string references to one-byte handles and back.
//
//   channel  payload          flow control
//   req      req   (req_t)    req_valid / req_stall
//   rsp      rsp   (rsp_t)    rsp_valid / rsp_stall
//
// One item is in work at a time. Direct cases go from classify straight to the
// result register; decode and fetch first take one registered table read; an
// intern scans the table memory one slot per cycle, from slot 1 up to the slot
// where it stops, at most slot SLOTS-1. The output register is loaded from the
// result register, and the next item can be accepted in the cycle after that
// load. Reset clears the slot valid bits at once, so no clearing pass is
// needed. The output register holds a stalled result while the next item is
// already accepted and worked on; that item then waits in its last state.
// ----------------------------------------------------------------------------
module value_handle_intern_table (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  vhit_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output vhit_pkg::rsp_t rsp
);

	vhit_pkg::dp_cmd_t cmd;
	vhit_pkg::dp_sts_t sts;

	vhit_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	vhit_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

	// A slot is only written when the scan found it usable.
	a_wr_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr |-> sts.hit)
		else $error("table write without a usable slot");

	// An accepted item blocks the input until its result is handed over.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("input not stalled after acceptance");

	// The output register is never overwritten while a stalled result waits.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(rsp_valid && rsp_stall))
		else $error("stalled result overwritten");

	// An exhausted table always reports handle zero.
	a_exhausted_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.exhausted) |-> (rsp.handle_out == 8'd0))
		else $error("exhausted result with nonzero handle");

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// value_handle_intern_table testbench
// Sends intern, decode and fetch items through the request channel and checks
// every result against a shadow copy of both slot tables kept in the bench.
// A directed opening covers the direct handles, slot reuse, null and empty
// strings and every handle range. Random traffic then fills both tables until
// they report exhaustion. Stalls and gaps vary by phase, and one phase includes
// a long stall on the result side.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 100;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	vhit_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	vhit_pkg::rsp_t rsp;

	value_handle_intern_table u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// Shadow copies of the two slot tables.
	logic [15:0] num_shadow [vhit_pkg::SLOTS];
	logic [15:0] str_shadow [vhit_pkg::SLOTS];

	vhit_pkg::req_t req_backlog [$];
	vhit_pkg::rsp_t due_rsps [$];
	logic [15:0] seen_values [$];

	int phase = 0;
	int hold_request = 0;
	int mismatches = 0;
	int results_checked = 0;
	int exhausted_seen = 0;
	int held_cycles = 0;
	int cycle_cnt = 0;
	int op_count [4] = '{default: 0};

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic void clear_shadow();
		for (int k = 0; k < vhit_pkg::SLOTS; k++) begin
			num_shadow[k] = '0;
			str_shadow[k] = '0;
		end
		str_shadow[0] = vhit_pkg::EMPTY_MARK;
		str_shadow[vhit_pkg::SLOTS-1] = vhit_pkg::MINUS_ONE;
	endfunction

	// Applies one item to the shadow tables and returns the result it yields.
	function automatic vhit_pkg::rsp_t predict_handle_op(input vhit_pkg::req_t r);
		vhit_pkg::rsp_t o;
		logic [5:0] idx;
		bit found;
		o = '0;
		idx = r.handle[5:0];
		found = 1'b0;
		case (r.op)
		vhit_pkg::OP_INTERN_NUM: begin
			if (r.value < 16'd128 || r.value == vhit_pkg::MINUS_ONE) begin
				o.handle_out = r.value[7:0];
			end else begin
				for (int k = 1; k < vhit_pkg::SLOTS; k++) begin
					if (!found && (num_shadow[k] == '0 || num_shadow[k] == r.value)) begin
						num_shadow[k] = r.value;
						o.handle_out = vhit_pkg::NUM_BASE | 8'(k);
						found = 1'b1;
					end
				end
				o.exhausted = !found;
			end
		end
		vhit_pkg::OP_INTERN_STR: begin
			if (r.str_ref == '0) begin
				o.handle_out = '0;
			end else if (r.str_empty) begin
				o.handle_out = vhit_pkg::STR_BASE;
			end else begin
				// The same reference is never looked up, so it takes a new slot.
				for (int k = 1; k < vhit_pkg::SLOTS; k++) begin
					if (!found && str_shadow[k] == '0) begin
						str_shadow[k] = r.str_ref;
						o.handle_out = vhit_pkg::STR_BASE | 8'(k);
						found = 1'b1;
					end
				end
				o.exhausted = !found;
			end
		end
		vhit_pkg::OP_DECODE: begin
			if (r.handle < vhit_pkg::NUM_BASE)
				o.value_out = {8'd0, r.handle};
			else if (r.handle == vhit_pkg::HANDLE_M1)
				o.value_out = vhit_pkg::MINUS_ONE;
			else if (int'(idx) >= vhit_pkg::SLOTS)
				o.value_out = '0;
			else if (r.handle < vhit_pkg::STR_BASE)
				o.value_out = num_shadow[idx];
			else
				o.value_out = str_shadow[idx];
		end
		vhit_pkg::OP_FETCH_STR: begin
			if (r.handle >= vhit_pkg::STR_BASE && int'(idx) < vhit_pkg::SLOTS)
				o.value_out = str_shadow[idx];
		end
		default: ;
		endcase
		return o;
	endfunction

	function automatic vhit_pkg::req_t make_req(input logic [1:0] op,
			input logic [15:0] value, input logic [15:0] sref, input logic sempty,
			input logic [7:0] handle);
		vhit_pkg::req_t r;
		r.op = op;
		r.value = value;
		r.str_ref = sref;
		r.str_empty = sempty;
		r.handle = handle;
		return r;
	endfunction

	// Random item: every field starts random; value, str_ref, str_empty and handle are then biased toward edge cases.
	function automatic vhit_pkg::req_t random_req();
		vhit_pkg::req_t r;
		int pick;
		r = vhit_pkg::req_t'({$urandom, $urandom});
		pick = $urandom_range(99, 0);
		if (pick < 35)
			r.op = vhit_pkg::OP_INTERN_NUM;
		else if (pick < 60)
			r.op = vhit_pkg::OP_INTERN_STR;
		else if (pick < 85)
			r.op = vhit_pkg::OP_DECODE;
		else
			r.op = vhit_pkg::OP_FETCH_STR;
		case ($urandom_range(9, 0))
		0, 1: r.value = 16'($urandom_range(127, 0));
		2: r.value = vhit_pkg::MINUS_ONE;
		3, 4, 5: begin
			if (seen_values.size() != 0)
				r.value = seen_values[$urandom_range(seen_values.size() - 1, 0)];
		end
		default: ;
		endcase
		if (r.op == vhit_pkg::OP_INTERN_NUM && r.value >= 16'd128 &&
				r.value != vhit_pkg::MINUS_ONE)
			seen_values.push_back(r.value);
		if ($urandom_range(9, 0) == 0)
			r.str_ref = '0;
		r.str_empty = ($urandom_range(9, 0) == 0);
		if ($urandom_range(1, 0) == 1)
			r.handle = 8'($urandom_range(255, 128));
		return r;
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Request driver. A new item is picked only once the previous one was taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else begin
			if (req_valid && !req_stall) begin
				due_rsps.push_back(predict_handle_op(req));
				op_count[req.op]++;
			end
			if (!req_valid || !req_stall) begin
				if (req_backlog.size() != 0 &&
						$urandom_range(99, 0) >= (phase == 0 ? 37 : phase == 1 ? 79 : 0)) begin
					req_valid <= 1'b1;
					req <= req_backlog.pop_front();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and stall generator.
	int hold_left = 0;
	bit hold_started = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		vhit_pkg::rsp_t want;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (due_rsps.size() == 0) begin
					$display("%0t: result with no item waiting: expected none, got %p",
						$time, rsp);
					mismatches++;
				end else begin
					want = due_rsps.pop_front();
					check_field("handle_out", want.handle_out, rsp.handle_out);
					check_field("value_out", want.value_out, rsp.value_out);
					check_field("exhausted", want.exhausted, rsp.exhausted);
					results_checked++;
					if (want.exhausted)
						exhausted_seen++;
				end
			end
			if (hold_request != 0 && !hold_started) begin
				hold_started <= 1'b1;
				hold_left <= hold_request;
				rsp_stall <= 1'b1;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				held_cycles <= held_cycles + 1;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= ($urandom_range(99, 0) < (phase == 0 ? 79 : phase == 1 ? 37 : 0));
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still due", cycle_cnt,
				due_rsps.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic wait_idle();
		while (req_backlog.size() != 0 || req_valid || due_rsps.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		clear_shadow();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Direct numbers, first slot, slot reuse and minus one.
		req_backlog.push_back(make_req(vhit_pkg::OP_INTERN_NUM, 16'd0, 16'($urandom),
			1'b1, 8'($urandom)));
		req_backlog.push_back(make_req(vhit_pkg::OP_INTERN_NUM, 16'd127, 16'($urandom),
			1'b0, 8'($urandom)));
		req_backlog.push_back(make_req(vhit_pkg::OP_INTERN_NUM, 16'd128, 16'($urandom),
			1'b0, 8'($urandom)));
		req_backlog.push_back(make_req(vhit_pkg::OP_INTERN_NUM, vhit_pkg::MINUS_ONE,
			16'($urandom), 1'b0, 8'($urandom)));
		req_backlog.push_back(make_req(vhit_pkg::OP_INTERN_NUM, 16'hFFFE, 16'($urandom),
			1'b1, 8'($urandom)));
		req_backlog.push_back(make_req(vhit_pkg::OP_INTERN_NUM, 16'd128, 16'($urandom),
			1'b0, 8'($urandom)));
		req_backlog.push_back(make_req(vhit_pkg::OP_INTERN_NUM, 16'h8000, 16'($urandom),
			1'b0, 8'($urandom)));
		// Null and empty strings, then the same reference stored twice.
		req_backlog.push_back(make_req(vhit_pkg::OP_INTERN_STR, 16'($urandom), 16'd0,
			1'b1, 8'($urandom)));
		req_backlog.push_back(make_req(vhit_pkg::OP_INTERN_STR, 16'($urandom), 16'h1234,
			1'b1, 8'($urandom)));
		req_backlog.push_back(make_req(vhit_pkg::OP_INTERN_STR, 16'($urandom), 16'hFFFF,
			1'b0, 8'($urandom)));
		req_backlog.push_back(make_req(vhit_pkg::OP_INTERN_STR, 16'($urandom), 16'hFFFF,
			1'b0, 8'($urandom)));
		req_backlog.push_back(make_req(vhit_pkg::OP_INTERN_STR, 16'($urandom), 16'h0001,
			1'b0, 8'($urandom)));
		// Decode across every handle range, including the edges of each.
		req_backlog.push_back(make_req(vhit_pkg::OP_DECODE, 16'($urandom), 16'($urandom),
			1'b0, 8'd0));
		req_backlog.push_back(make_req(vhit_pkg::OP_DECODE, 16'($urandom), 16'($urandom),
			1'b1, 8'd127));
		req_backlog.push_back(make_req(vhit_pkg::OP_DECODE, 16'($urandom), 16'($urandom),
			1'b0, vhit_pkg::NUM_BASE));
		req_backlog.push_back(make_req(vhit_pkg::OP_DECODE, 16'($urandom), 16'($urandom),
			1'b0, 8'd129));
		req_backlog.push_back(make_req(vhit_pkg::OP_DECODE, 16'($urandom), 16'($urandom),
			1'b0, 8'd191));
		req_backlog.push_back(make_req(vhit_pkg::OP_DECODE, 16'($urandom), 16'($urandom),
			1'b0, vhit_pkg::STR_BASE));
		req_backlog.push_back(make_req(vhit_pkg::OP_DECODE, 16'($urandom), 16'($urandom),
			1'b0, 8'd193));
		req_backlog.push_back(make_req(vhit_pkg::OP_DECODE, 16'($urandom), 16'($urandom),
			1'b0, 8'd254));
		req_backlog.push_back(make_req(vhit_pkg::OP_DECODE, 16'($urandom), 16'($urandom),
			1'b0, vhit_pkg::HANDLE_M1));
		// Fetch below the string range, the empty marker and the sealed last slot.
		req_backlog.push_back(make_req(vhit_pkg::OP_FETCH_STR, 16'($urandom),
			16'($urandom), 1'b0, 8'd191));
		req_backlog.push_back(make_req(vhit_pkg::OP_FETCH_STR, 16'($urandom),
			16'($urandom), 1'b0, vhit_pkg::STR_BASE));
		req_backlog.push_back(make_req(vhit_pkg::OP_FETCH_STR, 16'($urandom),
			16'($urandom), 1'b1, 8'd193));
		req_backlog.push_back(make_req(vhit_pkg::OP_FETCH_STR, 16'($urandom),
			16'($urandom), 1'b0, vhit_pkg::HANDLE_M1));
		// The sender stops here until every result is back.
		wait_idle();

		repeat (250) req_backlog.push_back(random_req());
		wait_idle();
		phase = 1;
		repeat (250) req_backlog.push_back(random_req());
		wait_idle();
		// No idling on either side, apart from one long stall on the result side
		// while the sender keeps offering items.
		phase = 2;
		repeat (200) req_backlog.push_back(random_req());
		hold_request = HOLD_CYCLES;
		wait_idle();
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("items: %0d intern number, %0d intern string, %0d decode, %0d fetch",
			op_count[vhit_pkg::OP_INTERN_NUM], op_count[vhit_pkg::OP_INTERN_STR],
			op_count[vhit_pkg::OP_DECODE], op_count[vhit_pkg::OP_FETCH_STR]);
		$display("%0d results checked, %0d with a full table, %0d cycles of long stall",
			results_checked, exhausted_seen, held_cycles);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
